>>> sv/sps_pkg.sv
// sps_pkg: shared types, constants and coil tables for the stepper phase sequencer
// no dependencies; used by the channel interfaces and the top level
package sps_pkg;

  localparam int CMD_W      = 2;
  localparam int COUNT_W    = 16;
  localparam int COIL_W     = 4;
  localparam int PHASE_W    = 3;
  localparam int STEPS_W    = 15;
  localparam int TICKS_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TICKS_W-1:0] DELAY_RESET = TICKS_W'(2000);
  localparam logic [STEPS_W-1:0] STEPS_MAX   = '1;
  localparam logic [TICKS_W-1:0] TICKS_MAX   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EIGHT_PHASE = 2'd0,
    CFG_STEP_DELAY  = 2'd1
  } cfg_idx_t;

  typedef logic [COIL_W-1:0] coil_t;

  // full-step pattern, indexed by phase mod 4
  function automatic coil_t four_pattern(input logic [1:0] ph);
    coil_t p;
    case (ph)
      2'd0:    p = 4'b0101;
      2'd1:    p = 4'b0110;
      2'd2:    p = 4'b1010;
      default: p = 4'b1001;
    endcase
    return p;
  endfunction

  // half-step pattern, indexed by the full phase
  function automatic coil_t eight_pattern(input logic [PHASE_W-1:0] ph);
    coil_t p;
    case (ph)
      3'd0:    p = 4'b0101;
      3'd1:    p = 4'b0100;
      3'd2:    p = 4'b0110;
      3'd3:    p = 4'b0010;
      3'd4:    p = 4'b1010;
      3'd5:    p = 4'b1000;
      3'd6:    p = 4'b1001;
      default: p = 4'b0001;
    endcase
    return p;
  endfunction

endpackage

>>> sv/sps_in_if.sv
// sps_in_if: command channel carrying command code and signed step count
// depends on sps_pkg for field widths
interface sps_in_if import sps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [COUNT_W-1:0] step_count;

  modport source (output valid, output command, output step_count, input ready);
  modport sink   (input valid, input command, input step_count, output ready);
endinterface

>>> sv/sps_out_if.sv
// sps_out_if: result channel carrying coil pattern and step status
// depends on sps_pkg for field widths
interface sps_out_if import sps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coil_pattern;
  logic              stepped;
  logic              busy_res;

  modport source (output valid, output coil_pattern, output stepped, output busy_res,
                  input ready);
  modport sink   (input valid, input coil_pattern, input stepped, input busy_res,
                  output ready);
endinterface

>>> sv/sps_cfg_if.sv
// sps_cfg_if: configuration write channel, register index plus write data
// depends on sps_pkg for index and data widths
interface sps_cfg_if import sps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/stepper_phase_sequencer_top.sv
// stepper_phase_sequencer_top: four-coil unipolar stepper phase sequencer
// depends on sps_pkg, sps_in_if, sps_out_if and sps_cfg_if

// Each transfer on in_ch is either a tick (one time unit), a move (signed step
// count, sign picks the direction, zero keeps it) or a stop. Every command
// transfer produces exactly one result transfer on out_ch with the coil drive,
// a stepped flag and a busy flag. The block is a two-register pipeline: the
// command lands in an input register, then one pass of short logic (saturating
// tick counter, delay compare, 3-bit phase up/down, pattern table lookup)
// updates the motor state and loads the result register. One command is taken
// per cycle; a command passes through the input register and then the result
// register before its result is offered on out_ch. Throughput drops only when
// out_ch stalls with both registers full. Register 0 selects the half-step
// table, register 1 sets the minimum ticks between steps (reset 2000); cfg_ch
// is always ready and should be written while idle.
module stepper_phase_sequencer_top import sps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sps_in_if.sink   in_ch,
  sps_out_if.source out_ch,
  sps_cfg_if.sink  cfg_ch
);

  // configuration registers
  logic               eight_mode_r;
  logic [TICKS_W-1:0] delay_r;

  // motor state
  logic [PHASE_W-1:0] phase_r,  phase_nxt;
  logic [STEPS_W-1:0] steps_r,  steps_nxt;
  logic               fwd_r,    fwd_nxt;
  logic [TICKS_W-1:0] ticks_r,  ticks_nxt;
  coil_t              coil_r,   coil_nxt;

  // input register
  logic                      s1_valid_r;
  logic [CMD_W-1:0]          s1_cmd_r;
  logic [COUNT_W-1:0]        s1_count_r;

  // result register
  logic  out_valid_r;
  coil_t out_coil_r,  out_coil_nxt;
  logic  out_step_r,  out_step_nxt;
  logic  out_busy_r;

  // pipeline flow control
  logic adv2;
  logic fire1;
  logic fire2;

  assign adv2        = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv2;
  assign fire1       = in_ch.valid && in_ch.ready;
  assign fire2       = s1_valid_r && adv2;

  // config writes, unknown indexes dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eight_mode_r <= 1'b0;
      delay_r      <= DELAY_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_EIGHT_PHASE: eight_mode_r <= cfg_ch.data[0];
        CFG_STEP_DELAY:  delay_r      <= cfg_ch.data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      s1_cmd_r   <= in_ch.command;
      s1_count_r <= in_ch.step_count;
    end
  end

  // update pass
  logic [TICKS_W-1:0] ticks_inc;
  logic               step_take;
  logic [PHASE_W-1:0] phase_step;
  logic [STEPS_W-1:0] steps_dec;
  coil_t              step_pat;
  logic [COUNT_W-1:0] neg_count;
  logic [STEPS_W-1:0] move_mag;

  always_comb begin
    ticks_inc  = (ticks_r == TICKS_MAX) ? ticks_r : ticks_r + TICKS_W'(1);
    phase_step = fwd_r ? phase_r + PHASE_W'(1) : phase_r - PHASE_W'(1);
    steps_dec  = steps_r - STEPS_W'(1);
    step_pat   = eight_mode_r ? eight_pattern(phase_step) : four_pattern(phase_step[1:0]);
    step_take  = (steps_r != '0) && (ticks_inc >= delay_r);

    // magnitude of the move, the most negative count saturates
    neg_count  = COUNT_W'(0) - s1_count_r;
    if (s1_count_r[COUNT_W-1]) begin
      move_mag = neg_count[COUNT_W-1] ? STEPS_MAX : neg_count[STEPS_W-1:0];
    end else begin
      move_mag = s1_count_r[STEPS_W-1:0];
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    steps_nxt    = steps_r;
    fwd_nxt      = fwd_r;
    ticks_nxt    = ticks_r;
    coil_nxt     = coil_r;
    out_coil_nxt = coil_r;
    out_step_nxt = 1'b0;
    case (s1_cmd_r)
      CMD_TICK: begin
        ticks_nxt = ticks_inc;
        if (step_take) begin
          ticks_nxt    = '0;
          phase_nxt    = phase_step;
          steps_nxt    = steps_dec;
          out_coil_nxt = step_pat;
          out_step_nxt = 1'b1;
          // coils go dark after the final step
          coil_nxt     = (steps_dec != '0) ? step_pat : '0;
        end
      end
      CMD_MOVE: begin
        if (s1_count_r[COUNT_W-1]) begin
          fwd_nxt = 1'b0;
        end else if (s1_count_r != '0) begin
          fwd_nxt = 1'b1;
        end
        steps_nxt = move_mag;
        if (move_mag == '0) begin
          coil_nxt = '0;
        end
        out_coil_nxt = (move_mag == '0) ? coil_t'(0) : coil_r;
      end
      CMD_STOP: begin
        steps_nxt    = '0;
        coil_nxt     = '0;
        out_coil_nxt = '0;
      end
      default: ; // unused code, state held
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      steps_r <= '0;
      fwd_r   <= 1'b0;
      ticks_r <= '0;
      coil_r  <= '0;
    end else if (fire2) begin
      phase_r <= phase_nxt;
      steps_r <= steps_nxt;
      fwd_r   <= fwd_nxt;
      ticks_r <= ticks_nxt;
      coil_r  <= coil_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      out_coil_r <= out_coil_nxt;
      out_step_r <= out_step_nxt;
      out_busy_r <= (steps_nxt != '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.coil_pattern = out_coil_r;
  assign out_ch.stepped      = out_step_r;
  assign out_ch.busy_res     = out_busy_r;

  // coils are only driven while a move is in progress
  a_idle_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
    (steps_r == '0) |-> (coil_r == '0))
    else $error("coil drive active with no steps remaining");

  // a step always restarts the timer
  a_step_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (fire2 && s1_cmd_r == CMD_TICK && step_take) |=> (ticks_r == '0))
    else $error("timer not restarted after step");

  // a stepping result never shows coils off
  a_step_pattern_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_step_r) |-> (out_coil_r != '0))
    else $error("step reported with coils off");

  // idle result without a step shows coils off
  a_idle_result_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_busy_r && !out_step_r) |-> (out_coil_r == '0))
    else $error("idle result with coils driven");

  // input stalls only when both registers are full and the output is held
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without back-pressure");

endmodule

>>> sim/stepper_check_pkg.sv
// stepper_check_pkg: coil sequence predictor and result scoreboard for the sequencer testbench
// depends on sps_pkg for field widths, command codes and register indexes
`timescale 1ns / 1ps
package stepper_check_pkg;
  import sps_pkg::*;

  localparam coil_t FULL_STEP_TAB [4] = '{4'b0101, 4'b0110, 4'b1010, 4'b1001};
  localparam coil_t HALF_STEP_TAB [8] = '{4'b0101, 4'b0100, 4'b0110, 4'b0010,
                                          4'b1010, 4'b1000, 4'b1001, 4'b0001};
  localparam int    REPORT_LINES  = 40;

  typedef struct packed {
    coil_t coil;
    logic  stepped;
    logic  busy;
  } coil_result_t;

  class stepper_scoreboard;
    bit                   half_step;
    logic [TICKS_W-1:0]   delay_ticks;
    logic [PHASE_W-1:0]   phase;
    logic [STEPS_W-1:0]   steps_todo;
    bit                   going_forward;
    logic [TICKS_W-1:0]   ticks;
    coil_t                drive;
    coil_result_t         expected_q[$];
    int                   errors;
    int                   results_seen;

    function new();
      half_step     = 1'b0;
      delay_ticks   = DELAY_RESET;
      phase         = '0;
      steps_todo    = '0;
      going_forward = 1'b0;
      ticks         = '0;
      drive         = '0;
      errors        = 0;
      results_seen  = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_EIGHT_PHASE: half_step = d[0];
        CFG_STEP_DELAY:  delay_ticks = d;
        default: ;
      endcase
    endfunction

    function coil_t pattern_at(logic [PHASE_W-1:0] ph);
      return half_step ? HALF_STEP_TAB[ph] : FULL_STEP_TAB[ph[1:0]];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // advance the motor state by one accepted command and queue its result
    function void note_command(logic [CMD_W-1:0] c, logic [COUNT_W-1:0] n);
      coil_result_t r;
      int unsigned  mag;
      r.coil    = drive;
      r.stepped = 1'b0;
      case (c)
        CMD_TICK: begin
          if (ticks != TICKS_MAX) ticks++;
          if (steps_todo != 0 && ticks >= delay_ticks) begin
            ticks      = '0;
            phase      = going_forward ? phase + 1'b1 : phase - 1'b1;
            steps_todo = steps_todo - 1'b1;
            r.coil     = pattern_at(phase);
            drive      = (steps_todo != 0) ? r.coil : '0;
            r.stepped  = 1'b1;
          end
        end
        CMD_MOVE: begin
          if (n[COUNT_W-1]) begin
            going_forward = 1'b0;
            mag = 32'h10000 - n;
          end else begin
            if (n != 0) going_forward = 1'b1;
            mag = n;
          end
          if (mag > STEPS_MAX) mag = STEPS_MAX;
          steps_todo = mag[STEPS_W-1:0];
          if (mag == 0) drive = '0;
          r.coil = drive;
        end
        CMD_STOP: begin
          steps_todo = '0;
          drive      = '0;
          r.coil     = '0;
        end
        default: ;
      endcase
      r.busy = (steps_todo != 0);
      expected_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= REPORT_LINES) $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    task check_result(coil_t coil, logic stepped, logic busy);
      coil_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected, coil %b", coil));
        return;
      end
      want = expected_q.pop_front();
      if (coil !== want.coil)
        report($sformatf("coil_pattern %b, expected %b", coil, want.coil));
      if (stepped !== want.stepped)
        report($sformatf("stepped %b, expected %b", stepped, want.stepped));
      if (busy !== want.busy)
        report($sformatf("busy_res %b, expected %b", busy, want.busy));
    endtask
  endclass

endpackage

>>> sim/tb_top.sv
// tb_top: self-checking testbench for stepper_phase_sequencer_top, checks every
// result transfer against a predictor under random sender gaps and receiver stalls
// depends on sps_pkg, the three channel interfaces, stepper_check_pkg and the block
`timescale 1ns / 1ps
module tb_top;
  import sps_pkg::*;
  import stepper_check_pkg::*;

  // command code 3 has no meaning; the block should pass it through untouched
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int               CYCLE_LIMIT  = 1_000_000;
  // idle margin after the last expected result has come back
  localparam int               DRAIN_CYCLES = 8;
  // enough ticks to pin the elapsed counter at its ceiling
  localparam int               SATURATE_RUN = 65600;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   burst_left;
  int   stall_left = 0;
  rx_mode_t stall_mode = RX_FREE;

  stepper_scoreboard sb;

  sps_in_if  in_ch ();
  sps_out_if out_ch ();
  sps_cfg_if cfg_ch ();

  stepper_phase_sequencer_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, counted from the very first edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: switches between four stall styles, each held for a random stretch, so that
  // stalls land on every pipeline state, including long free-running stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RX_FREE:  out_ch.ready <= 1'b1;
      RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ch.ready <= ($urandom_range(0, 1) != 0);
      default:  out_ch.ready <= (stall_left[2:0] != 3'd0);
    endcase
  end

  // monitor: sample every transfer at the clock edge, check results, feed the predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.coil_pattern, out_ch.stepped, out_ch.busy_res);
      if (in_ch.valid && in_ch.ready)
        sb.note_command(in_ch.command, in_ch.step_count);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(cfg_idx_t'(cfg_ch.index), cfg_ch.data);
    end
  end

  // one command transfer; valid stays high afterwards so back-to-back transfers
  // follow without a gap; a random gap before a new burst may lower it first
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [COUNT_W-1:0] n,
                           input bit steady = 1'b0);
    int gap;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= c;
    in_ch.step_count <= n;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic tick_run(input int n, input bit steady = 1'b0);
    repeat (n) send_item(CMD_TICK, COUNT_W'($urandom), steady);
  endtask

  // hold the sender off until every expected result has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers back to back, only while the block is idle
  task automatic configure(input bit half, input logic [CFG_DATA_W-1:0] delay);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_EIGHT_PHASE;
    cfg_ch.data  <= CFG_DATA_W'(half);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_STEP_DELAY;
    cfg_ch.data  <= delay;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly short moves either way, some zero, some at the range ends, some anything
  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    logic [COUNT_W-1:0] mag;
    r = $urandom_range(0, 99);
    mag = COUNT_W'($urandom_range(1, 6));
    if (r < 60) return $urandom_range(0, 1) ? mag : -mag;
    if (r < 70) return '0;
    if (r < 80) begin
      case ($urandom_range(0, 2))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        default: return 16'h8001;
      endcase
    end
    return COUNT_W'($urandom);
  endfunction

  // random traffic: mostly a move followed by a run of ticks, the rest noise,
  // stops and dead command codes; dead codes do not count toward n_items
  task automatic random_phase(input int n_items);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_item(CMD_MOVE, pick_count());
        len = $urandom_range(1, 24);
        tick_run(len);
        sent += len + 1;
      end else if (kind == 7) begin
        send_item(CMD_STOP, COUNT_W'($urandom));
        sent++;
      end else if (kind == 8) begin
        send_item(CMD_UNUSED, COUNT_W'($urandom));
      end else begin
        len = $urandom_range(1, 6);
        tick_run(len);
        sent += len;
      end
      // now and then let the pipeline run completely dry
      if ($urandom_range(0, 39) == 0) wait_idle();
    end
  endtask

  // directed checks under the reset settings: full step, 2000-tick delay
  task automatic directed_reset_settings();
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_MOVE, 16'd3);         // forward
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_MOVE, -16'sd2);       // reverse replaces the running move
    send_item(CMD_UNUSED, 16'h5A5A);
    send_item(CMD_STOP, 16'h1234);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_MOVE, 16'h0000);      // zero keeps direction, powers off
    send_item(CMD_MOVE, 16'h8000);      // most negative saturates to 32767 steps
    send_item(CMD_MOVE, 16'h7FFF);
    send_item(CMD_MOVE, 16'h8001);
    send_item(CMD_STOP, 16'h0000);
    send_item(CMD_MOVE, 16'hFFFF);      // single backward step
    tick_run(2000);                     // reaches the reset delay, last step clears coils
  endtask

  // directed checks with zero delay: a step on every tick
  task automatic directed_zero_delay();
    send_item(CMD_MOVE, 16'd3);
    tick_run(4);                        // three steps then nothing left
    send_item(CMD_MOVE, 16'd5);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_MOVE, 16'h0000);      // zero move switches coils off mid-run
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_MOVE, -16'sd4);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_STOP, 16'h0000);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_UNUSED, 16'h0000);
  endtask

  task automatic run_phase(input bit half, input logic [CFG_DATA_W-1:0] delay,
                           input int n_items);
    configure(half, delay);
    random_phase(n_items);
    wait_idle();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_TICK;
    in_ch.step_count <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_EIGHT_PHASE;
    cfg_ch.data      <= '0;
    burst_left       = 0;
    sb = new();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_reset_settings();
    wait_idle();

    configure(1'b1, 16'd0);
    directed_zero_delay();
    random_phase(70);
    wait_idle();

    run_phase(1'b0, 16'd1,  65);
    run_phase(1'b1, 16'd2,  65);
    run_phase(1'b0, 16'd0,  65);
    run_phase(1'b1, 16'd5,  65);
    run_phase(1'b0, 16'd3,  65);
    run_phase(1'b1, 16'd1,  65);

    // largest delay: the elapsed count must stick at its ceiling, so the first
    // tick after a move steps at once and the next one does not
    configure(1'b1, 16'hFFFF);
    send_item(CMD_STOP, 16'h0000);
    tick_run(SATURATE_RUN, 1'b1);
    send_item(CMD_MOVE, 16'd2);
    tick_run(3);
    send_item(CMD_MOVE, 16'hFFFF);
    send_item(CMD_TICK, 16'h0000);
    random_phase(30);
    wait_idle();

    run_phase(1'b0, 16'd2, 65);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/sps_pkg.sv
sv/sps_in_if.sv
sv/sps_out_if.sv
sv/sps_cfg_if.sv
sv/stepper_phase_sequencer_top.sv
sim/stepper_check_pkg.sv
sim/tb_top.sv
